// ----- rtl/mpd_pkg.sv -----
`default_nettype none

package mpd_pkg;

    // Largest chunk the point store can hold.
    localparam int MAX_CHUNK   = 1024;
    localparam int ADDR_W      = $clog2(MAX_CHUNK);
    localparam int FILL_W      = $clog2(MAX_CHUNK + 1);

    // Configuration port.
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int CHUNK_LEN_W = 11;
    localparam logic [CHUNK_LEN_W-1:0] CHUNK_LEN_RESET = CHUNK_LEN_W'(10);

    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATE_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LENGTH    = CFG_IDX_W'(1);

    // Command queue between the front and the back. Depth is a power of two.
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_point;

    // One finished command: an optional min/max pair, then an optional point.
    typedef struct packed {
        logic   pair;
        t_point first;
        t_point second;
        logic   pt;
        t_point point;
        logic   done;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_POINT
    } t_phase;

endpackage

`default_nettype wire

// ----- rtl/minmax_polyline_decimator_core.sv -----
// Min/max polyline decimator. Points of one polyline arrive one per
// transaction on the push side, with line_end marking the closing point.
// With decimation off every point comes out unchanged. With decimation on,
// the first and closing points come out as they are, and every chunk of
// chunk_length interior points is reduced to its minimum-y and maximum-y
// points, ordered by increasing x (maximum first on equal x). The final
// chunk of a polyline may be shorter and is emitted just before the
// closing point. A point is accepted on every cycle in which full is low;
// full rises only when the four-entry command queue plus the command in
// flight could not take one more. Each input transaction causes zero to
// three result transactions, delivered one per cycle on the pop side while
// pop is held, so a transaction with three results holds the result side
// while the front keeps accepting points. When the queue is empty, the
// command for an accepted transaction is registered in the front and then
// written into the command queue, after which its first result is on the
// pop side and can be popped. The chunk store is a 1024-entry memory with
// one write and one registered read per cycle; it needs no clearing after
// reset, so the block accepts points as soon as reset is released.
// Configuration writes take effect for the next accepted point and are
// meant to be made while no results are outstanding.

`default_nettype none

module minmax_polyline_decimator_core import mpd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Point input, queue style.
    input  wire logic                  push,
    output logic                       full,
    input  wire logic signed [15:0]    i_sample_x,
    input  wire logic signed [15:0]    i_sample_y,
    input  wire logic                  i_line_end,
    // Result output, queue style.
    output logic                       empty,
    input  wire logic                  pop,
    output logic signed [15:0]         o_out_x,
    output logic signed [15:0]         o_out_y,
    output logic                       o_last_of_run,
    output logic                       o_polyline_done
);

    logic                  in_valid;
    t_point                in_point;
    t_cmd                  s1_cmd;
    logic                  s1_valid;
    t_cmd                  head;
    logic                  head_rd;
    logic                  q_empty;
    logic [CMDQ_CNT_W-1:0] q_count;

    // The command in flight between the front and the queue is counted
    // as occupied space, so an accepted point always finds room.
    assign full = (q_count + CMDQ_CNT_W'(s1_valid)) >= CMDQ_CNT_W'(CMDQ_DEPTH);

    assign in_valid   = push && !full;
    assign in_point.x = i_sample_x;
    assign in_point.y = i_sample_y;

    // Front: configuration, chunk tracking, point store and pair ordering.
    mpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (in_valid),
        .i_point     (in_point),
        .i_line_end  (i_line_end),
        .o_cmd       (s1_cmd),
        .o_cmd_valid (s1_valid)
    );

    // Short queue that lets the front keep accepting points while the
    // result side is stalled or busy with a multi-result command.
    mpd_cmd_fifo u_cmd_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (s1_valid),
        .i_wr_data (s1_cmd),
        .i_rd      (head_rd),
        .o_rd_data (head),
        .o_empty   (q_empty),
        .o_count   (q_count)
    );

    // Back: steps through the results of the command at the queue head.
    mpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_pop     (pop && !q_empty),
        .o_head_rd (head_rd),
        .o_x       (o_out_x),
        .o_y       (o_out_y),
        .o_last    (o_last_of_run),
        .o_done    (o_polyline_done)
    );

    assign empty = q_empty;

endmodule

`default_nettype wire

// ----- rtl/mpd_front.sv -----
`default_nettype none

module mpd_front import mpd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    input  wire t_point                i_point,
    input  wire logic                  i_line_end,
    output t_cmd                       o_cmd,
    output logic                       o_cmd_valid
);

    logic                   r_dec_en;
    logic [CHUNK_LEN_W-1:0] r_chunk_len;
    logic                   r_started;
    logic                   n_started;
    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      n_fill;
    t_point                 r_min;
    t_point                 r_max;
    t_point                 n_min;
    t_point                 n_max;

    logic                   add_pt;
    logic                   flush;
    logic                   pass;
    logic [FILL_W-1:0]      fill_inc;
    logic [FILL_W-1:0]      eff_len;
    logic [FILL_W-1:0]      mid_idx;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;

    t_point                 mem [MAX_CHUNK];
    t_point                 r_mid;

    logic                   r_s1_valid;
    logic                   r_s1_pair;
    logic                   r_s1_pt;
    logic                   r_s1_done;
    t_point                 r_s1_min;
    t_point                 r_s1_max;
    t_point                 r_s1_point;
    t_point                 mx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_en    <= 1'b0;
            r_chunk_len <= CHUNK_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DECIMATE_ENABLE: r_dec_en    <= i_cfg_data[0];
                CFG_CHUNK_LENGTH:    r_chunk_len <= i_cfg_data[CHUNK_LEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        if (r_chunk_len == '0) begin
            eff_len = FILL_W'(1);
        end else if (FILL_W'(r_chunk_len) > FILL_W'(MAX_CHUNK)) begin
            eff_len = FILL_W'(MAX_CHUNK);
        end else begin
            eff_len = FILL_W'(r_chunk_len);
        end
    end

    assign fill_inc = r_fill + FILL_W'(1);

    always_comb begin
        add_pt    = 1'b0;
        flush     = 1'b0;
        pass      = 1'b0;
        n_started = r_started;
        priority if (!r_dec_en) begin
            flush     = (r_fill != '0);
            pass      = 1'b1;
            n_started = !i_line_end;
        end else if (!r_started) begin
            pass      = 1'b1;
            n_started = !i_line_end;
        end else if (i_line_end) begin
            flush     = (r_fill != '0);
            pass      = 1'b1;
            n_started = 1'b0;
        end else begin
            add_pt    = 1'b1;
            flush     = (fill_inc >= eff_len);
        end
    end

    // Running minimum and maximum: the first strict extreme wins.
    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (add_pt) begin
            if (r_fill == '0) begin
                n_min = i_point;
                n_max = i_point;
            end else begin
                if (i_point.y < r_min.y) n_min = i_point;
                if (i_point.y > r_max.y) n_max = i_point;
            end
        end
    end

    always_comb begin
        if (flush) begin
            n_fill = '0;
        end else if (add_pt) begin
            n_fill = fill_inc;
        end else begin
            n_fill = r_fill;
        end
    end

    assign mid_idx = (add_pt ? fill_inc : r_fill) >> 1;
    assign rd_addr = mid_idx[ADDR_W-1:0];
    assign wr_addr = r_fill[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_fill    <= '0;
        end else if (i_valid) begin
            r_started <= n_started;
            r_fill    <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    // Point store; the middle entry is read with the write forwarded.
    always_ff @(posedge i_clk) begin
        if (i_valid && add_pt) begin
            mem[wr_addr] <= i_point;
        end
        if (i_valid) begin
            r_mid <= (add_pt && (rd_addr == wr_addr)) ? i_point : mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid && (flush || pass);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1_pair  <= flush;
            r_s1_min   <= n_min;
            r_s1_max   <= n_max;
            r_s1_pt    <= pass;
            r_s1_point <= i_point;
            r_s1_done  <= i_line_end;
        end
    end

    assign mx = (r_mid.y == r_s1_max.y) ? r_mid : r_s1_max;

    always_comb begin
        o_cmd.pair  = r_s1_pair;
        o_cmd.pt    = r_s1_pt;
        o_cmd.point = r_s1_point;
        o_cmd.done  = r_s1_done;
        if (r_s1_min.x < mx.x) begin
            o_cmd.first  = r_s1_min;
            o_cmd.second = mx;
        end else begin
            o_cmd.first  = mx;
            o_cmd.second = r_s1_min;
        end
    end

    assign o_cmd_valid = r_s1_valid;

endmodule

`default_nettype wire

// ----- rtl/mpd_cmd_fifo.sv -----
`default_nettype none

module mpd_cmd_fifo import mpd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr,
    input  wire t_cmd                  i_wr_data,
    input  wire logic                  i_rd,
    output t_cmd                       o_rd_data,
    output logic                       o_empty,
    output logic [CMDQ_CNT_W-1:0]      o_count
);

    t_cmd                  r_slot [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= r_wr_ptr + CMDQ_PTR_W'(1);
            if (i_rd) r_rd_ptr <= r_rd_ptr + CMDQ_PTR_W'(1);
            if (i_wr && !i_rd) begin
                r_count <= r_count + CMDQ_CNT_W'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - CMDQ_CNT_W'(1);
            end
        end
    end

    assign o_rd_data = r_slot[r_rd_ptr];
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CMDQ_CNT_W'(CMDQ_DEPTH))
        else $error("command queue count exceeds its depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |-> (r_count != CMDQ_CNT_W'(CMDQ_DEPTH)))
        else $error("command written into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> (r_count != '0))
        else $error("command read from an empty queue");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[CMDQ_PTR_W-1:0])
        else $error("queue pointers disagree with the count");

endmodule

`default_nettype wire

// ----- rtl/mpd_back.sv -----
`default_nettype none

module mpd_back import mpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_head,
    input  wire logic        i_pop,
    output logic             o_head_rd,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y,
    output logic             o_last,
    output logic             o_done
);

    t_phase r_phase;
    t_phase n_phase;
    t_phase cur;
    t_point sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        // A command without a pair starts directly on its point.
        cur = ((r_phase == PH_FIRST) && !i_head.pair) ? PH_POINT : r_phase;
        sel       = i_head.point;
        o_last    = 1'b1;
        o_done    = 1'b0;
        n_phase   = r_phase;
        o_head_rd = 1'b0;
        unique case (cur)
            PH_FIRST: begin
                sel    = i_head.first;
                o_last = 1'b0;
            end
            PH_SECOND: begin
                sel    = i_head.second;
                o_last = !i_head.pt;
            end
            PH_POINT: begin
                sel    = i_head.point;
                o_done = i_head.done;
            end
            default: begin
                sel    = i_head.point;
            end
        endcase
        if (i_pop) begin
            if (o_last) begin
                n_phase   = PH_FIRST;
                o_head_rd = 1'b1;
            end else if (cur == PH_FIRST) begin
                n_phase   = PH_SECOND;
            end else begin
                n_phase   = PH_POINT;
            end
        end
    end

    assign o_x = sel.x;
    assign o_y = sel.y;

endmodule

`default_nettype wire
